FILE: rtl/sias_pkg.sv
// Package for the sign-in anomaly scorer: constants, types and shared functions.
`default_nettype none

package sias_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 16;
   localparam int DEFAULT_FAIL_LIMIT   = 5;
   localparam int QUEUE_DEPTH          = 2;
   localparam int DIV_STEPS            = 16;

   localparam logic [15:0] Q_ONE           = 16'd65535;
   localparam logic [15:0] THRESHOLD_RESET = 16'd32768;
   localparam logic [31:0] RECENT_SPAN_MS  = 32'd60000;
   localparam logic [7:0]  QUIET_COUNT     = 8'd5;
   localparam logic [7:0]  FAIL_CAP        = 8'd255;
   localparam logic [15:0] FREQ_STEP       = 16'd13107;

   // Reciprocals: floor(x / 10) for x below 2^18 and floor(x / 5) for x below 2^19.
   localparam logic [17:0] TENTH_RECIP = 18'd209716;
   localparam int          TENTH_SHIFT = 21;
   localparam logic [18:0] FIFTH_RECIP = 19'd419431;
   localparam int          FIFTH_SHIFT = 21;

   typedef struct packed {
      logic [15:0] match_score;
      logic [31:0] time_ms;
      logic [15:0] failure_part;
   } sias_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_SUM,
      ST_MUL,
      ST_OUT
   } sias_state_type;

   // Lower end of the proximity ramp: floor(3 * threshold / 10).
   function automatic logic [15:0] ramp_low(input logic [15:0] thr);
      logic [17:0] thr3;
      logic [36:0] prod;
      thr3 = {2'b00, thr} + {1'b0, thr, 1'b0};
      prod = {19'd0, thr3} * {19'd0, TENTH_RECIP};
      return prod[TENTH_SHIFT+15:TENTH_SHIFT];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sias_if.sv
// Request and response channel interfaces of the sign-in anomaly scorer.
`default_nettype none

interface sias_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] match_score;
   logic        succeeded;
   logic [31:0] time_ms;

   modport source (output valid, output match_score, output succeeded, output time_ms,
                   input ready);
   modport sink (input valid, input match_score, input succeeded, input time_ms,
                 output ready);
endinterface

interface sias_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] anomaly_score;
   logic [15:0] failure_part;
   logic [15:0] proximity_part;
   logic [15:0] frequency_part;

   modport source (output valid, output anomaly_score, output failure_part,
                   output proximity_part, output frequency_part, input ready);
   modport sink (input valid, input anomaly_score, input failure_part,
                 input proximity_part, input frequency_part, output ready);
endinterface

`default_nettype wire

FILE: rtl/sias_front.sv
// Front end: accepts requests, tracks the failure run and forms the failure score.
`default_nettype none

module sias_front
   import sias_pkg::*;
#(
   parameter int FAIL_LIMIT = DEFAULT_FAIL_LIMIT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sias_req_if.sink    req,
   output logic        push_valid,
   input  wire logic   push_ready,
   output sias_item_type push_item
);

   localparam logic [7:0]  LIMIT     = 8'(FAIL_LIMIT);
   localparam logic [15:0] STEP_QUOT = 16'(65535 / FAIL_LIMIT);
   localparam logic [8:0]  STEP_REM  = 9'(65535 % FAIL_LIMIT);

   logic [7:0]  fail_run_ff, fail_run_in;
   logic [15:0] fail_quot_ff, fail_quot_in;
   logic [7:0]  fail_rem_ff, fail_rem_in;
   logic [8:0]  rem_sum;
   logic        carry;
   logic [16:0] quot_sum;
   logic [15:0] failure_part;
   logic        accept;

   assign accept     = req.valid && push_ready;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   // The quotient run_count * 65535 / FAIL_LIMIT is kept as quotient and remainder
   // and stepped by one count at a time.
   always_comb begin
      rem_sum  = {1'b0, fail_rem_ff} + STEP_REM;
      carry    = (rem_sum >= {1'b0, LIMIT});
      quot_sum = {1'b0, fail_quot_ff} + {1'b0, STEP_QUOT} + {16'd0, carry};

      fail_run_in  = fail_run_ff;
      fail_quot_in = fail_quot_ff;
      fail_rem_in  = fail_rem_ff;
      if (req.succeeded) begin
         fail_run_in  = '0;
         fail_quot_in = '0;
         fail_rem_in  = '0;
      end else if (fail_run_ff != FAIL_CAP) begin
         fail_run_in = fail_run_ff + 8'd1;
         if (fail_run_ff < LIMIT) begin
            fail_quot_in = quot_sum[15:0];
            fail_rem_in  = carry ? 8'(rem_sum - {1'b0, LIMIT}) : rem_sum[7:0];
         end
      end

      if (fail_run_in == 8'd0) begin
         failure_part = '0;
      end else if (fail_run_in >= LIMIT) begin
         failure_part = Q_ONE;
      end else begin
         failure_part = fail_quot_in;
      end
   end

   assign push_item.match_score  = req.match_score;
   assign push_item.time_ms      = req.time_ms;
   assign push_item.failure_part = failure_part;

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_run_ff  <= '0;
         fail_quot_ff <= '0;
         fail_rem_ff  <= '0;
      end else if (accept) begin
         fail_run_ff  <= fail_run_in;
         fail_quot_ff <= fail_quot_in;
         fail_rem_ff  <= fail_rem_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sias_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none

module sias_queue
   import sias_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_valid,
   output logic        push_ready,
   input  wire sias_item_type push_item,
   output logic        pop_valid,
   input  wire logic   pop_ready,
   output sias_item_type pop_item
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   sias_item_type slots_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sias_div.sv
// Restoring divider, one quotient bit per cycle, for quotients known to fit in 16 bits.
`default_nettype none

module sias_div
   import sias_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] numer,
   input  wire logic [15:0] denom,
   output logic             busy,
   output logic [15:0]      quot
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quot_ff, quot_in;
   logic [15:0] den_ff;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [17:0] trial;
   logic        fits;

   assign busy = busy_ff;
   assign quot = quot_ff;

   always_comb begin
      trial   = {1'b0, rem_ff, quot_ff[15]} - {2'b00, den_ff};
      fits    = !trial[17];
      rem_in  = fits ? trial[15:0] : {rem_ff[14:0], quot_ff[15]};
      quot_in = {quot_ff[14:0], fits};
      step_in = step_ff + 5'd1;
      busy_in = (step_in != 5'(DIV_STEPS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // The upper half of the numerator is below the divisor, so it seeds the remainder.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= numer[31:16];
         quot_ff <= numer[15:0];
         den_ff  <= denom;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sias_back.sv
// Back end: timestamp ring, recent-attempt count, proximity division and weighted sum.
`default_nettype none

module sias_back
   import sias_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] threshold,
   input  wire logic [15:0] ramp_lo,
   input  wire logic        pop_valid,
   output logic             pop_ready,
   input  wire sias_item_type pop_item,
   sias_rsp_if.source       rsp
);

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FW = $clog2(WINDOW_DEPTH + 1);

   sias_state_type state_ff, state_in;

   logic [31:0] ring_mem [WINDOW_DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] slot_ff, slot_in;
   logic [FW-1:0] filled_ff, filled_in;
   logic [FW-1:0] rd_idx_ff;
   logic          rd_pend_ff;
   logic [FW-1:0] recent_ff;

   sias_item_type item_ff;
   logic          prox_zero_ff;
   logic [20:0]   wsum_ff;
   logic [15:0]   total_ff;
   logic [15:0]   prox_ff;
   logic [15:0]   freq_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_total_ff, rsp_fail_ff, rsp_prox_ff, rsp_freq_ff;

   // Control strobes from the sequencer.
   logic take, do_load, do_run, do_sum, do_mul, out_load, rd_en, sweep_done, run_done;

   logic [15:0] diff;
   logic [15:0] denom;
   logic [31:0] numer;
   logic        div_busy;
   logic [15:0] div_quot;
   logic [31:0] age;
   logic [7:0]  recent_ext;
   logic [7:0]  over;
   logic [15:0] freq_part;
   logic [15:0] prox_part;
   logic [37:0] prod;

   sias_div u_div (
      .clock (clock),
      .reset (reset),
      .start (do_load),
      .numer (numer),
      .denom (denom),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // Ramp numerator (score - lo) * 65535 by shift and subtract.
   assign diff  = item_ff.match_score - ramp_lo;
   assign denom = threshold - ramp_lo;
   assign numer = {diff, 16'd0} - {16'd0, diff};

   assign sweep_done = (rd_idx_ff == filled_ff) && !rd_pend_ff;
   assign age        = item_ff.time_ms - rd_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (pop_valid) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_RUN;
         ST_RUN:  if (!div_busy && sweep_done) state_in = ST_SUM;
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT:  if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pop_ready = 1'b0;
      do_load   = 1'b0;
      do_run    = 1'b0;
      do_sum    = 1'b0;
      do_mul    = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: pop_ready = 1'b1;
         ST_LOAD: do_load   = 1'b1;
         ST_RUN:  do_run    = 1'b1;
         ST_SUM:  do_sum    = 1'b1;
         ST_MUL:  do_mul    = 1'b1;
         ST_OUT:  out_load  = !rsp_valid_ff || rsp.ready;
         default: pop_ready = 1'b0;
      endcase
   end

   assign take     = pop_ready && pop_valid;
   assign rd_en    = do_run && (rd_idx_ff != filled_ff);
   assign run_done = do_run && !div_busy && sweep_done;

   always_comb begin
      slot_in   = (slot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + AW'(1);
      filled_in = (filled_ff == FW'(WINDOW_DEPTH)) ? filled_ff : filled_ff + FW'(1);
   end

   // Frequency score: at most four steps above the normal count before saturation.
   always_comb begin
      recent_ext = 8'(recent_ff);
      over       = recent_ext - QUIET_COUNT;
      if (recent_ext <= QUIET_COUNT) begin
         freq_part = '0;
      end else begin
         case (over)
            8'd1:    freq_part = FREQ_STEP;
            8'd2:    freq_part = 16'(2 * FREQ_STEP);
            8'd3:    freq_part = 16'(3 * FREQ_STEP);
            8'd4:    freq_part = 16'(4 * FREQ_STEP);
            default: freq_part = Q_ONE;
         endcase
      end
      prox_part = prox_zero_ff ? 16'd0 : div_quot;
      prod      = {19'd0, wsum_ff[20:2]} * {19'd0, FIFTH_RECIP};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         filled_ff    <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         recent_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_load) begin
            slot_ff    <= slot_in;
            filled_ff  <= filled_in;
            rd_idx_ff  <= '0;
            rd_pend_ff <= 1'b0;
            recent_ff  <= '0;
         end else if (do_run) begin
            rd_pend_ff <= rd_en;
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + FW'(1);
            end
            if (rd_pend_ff && (age < RECENT_SPAN_MS)) begin
               recent_ff <= recent_ff + FW'(1);
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         ring_mem[slot_ff] <= item_ff.time_ms;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= pop_item;
      end
      if (do_load) begin
         prox_zero_ff <= (item_ff.match_score < ramp_lo) || (item_ff.match_score >= threshold);
      end
      // Weighted sum 40F + 35P + 25Q is five times 8F + 7P + 5Q; the total is that over 20.
      if (do_sum) begin
         prox_ff <= prox_part;
         freq_ff <= freq_part;
         wsum_ff <= {2'b00, item_ff.failure_part, 3'b000}
                  + {2'b00, prox_part, 3'b000} - {5'd0, prox_part}
                  + {3'b000, freq_part, 2'b00} + {5'd0, freq_part};
      end
      if (do_mul) begin
         total_ff <= prod[FIFTH_SHIFT+15:FIFTH_SHIFT];
      end
      if (out_load) begin
         rsp_total_ff <= total_ff;
         rsp_fail_ff  <= item_ff.failure_part;
         rsp_prox_ff  <= prox_ff;
         rsp_freq_ff  <= freq_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.anomaly_score  = rsp_total_ff;
   assign rsp.failure_part   = rsp_fail_ff;
   assign rsp.proximity_part = rsp_prox_ff;
   assign rsp.frequency_part = rsp_freq_ff;

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_idx_ff < filled_ff))
      else $error("ring read beyond the written entries");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (recent_ff <= filled_ff) && (filled_ff <= FW'(WINDOW_DEPTH)))
      else $error("recent count exceeds the filled entries");

   a_run_exit: assert property (@(posedge clock) disable iff (reset)
      run_done |=> (state_ff == ST_SUM))
      else $error("sequencer did not leave the run phase when work was done");

   a_div_in_run: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_RUN))
      else $error("divider busy outside the run phase");

endmodule

`default_nettype wire

FILE: rtl/sign_in_anomaly_scorer.sv
// Sign-in anomaly scorer: one request per sign-in attempt gives one response of four scores.
//
// The request channel carries a match score, a success flag and a millisecond
// timestamp; the response channel carries the weighted anomaly score and its failure,
// proximity and frequency parts, all Q0.16. Both are valid/ready handshakes.
// The user must write the threshold register through csr_we/csr_wdata only while the
// block is idle; the block itself does not enforce this. The front end takes a request
// and queues it (two entries); the back end handles one request at a time. In the back
// end the filled entries of the timestamp ring (at most WINDOW_DEPTH) are scanned
// through one read port, one entry a cycle, while the bit-serial divider forms the
// proximity ramp.
// Reset clears the failure run, the ring fill and the queue and sets the threshold
// to 32768; the ring entries themselves are not cleared. A stalled response waits in
// the output register while the next request is already being worked on; requests
// back up into the queue and then stall the request channel.
`default_nettype none

module sign_in_anomaly_scorer
   import sias_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
   parameter int FAIL_LIMIT   = DEFAULT_FAIL_LIMIT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   sias_req_if.sink         req_chan,
   sias_rsp_if.source       rsp_chan
);

   logic [15:0] threshold_ff;
   logic [15:0] ramp_lo_ff;

   logic          push_valid, push_ready;
   sias_item_type push_item;
   logic          pop_valid, pop_ready;
   sias_item_type pop_item;

   // The ramp's lower end is precomputed on each write.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         ramp_lo_ff   <= ramp_low(THRESHOLD_RESET);
      end else if (csr_we) begin
         threshold_ff <= csr_wdata;
         ramp_lo_ff   <= ramp_low(csr_wdata);
      end
   end

   sias_front #(
      .FAIL_LIMIT (FAIL_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   sias_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sias_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .ramp_lo   (ramp_lo_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the sign-in anomaly scorer: directed and random attempts checked against a scoring model.
`default_nettype none

module tb_top
   import sias_pkg::*;
();

   localparam int RING_DEPTH    = DEFAULT_WINDOW_DEPTH;
   localparam int RUN_LIMIT     = DEFAULT_FAIL_LIMIT;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [15:0] anomaly_score;
      logic [15:0] failure_part;
      logic [15:0] proximity_part;
      logic [15:0] frequency_part;
   } score_set_type;

   class score_ledger_type;
      bit [15:0]  threshold;
      bit [7:0]   fail_run;
      bit [31:0]  stamps [RING_DEPTH];
      int unsigned slot;
      int unsigned filled;
      score_set_type pending_scores [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned peak_run;
      int unsigned busy_hits;
      int unsigned ramp_hits;

      function new();
         threshold = THRESHOLD_RESET;
         fail_run = 0;
         slot = 0;
         filled = 0;
         mismatches = 0;
         checked = 0;
         peak_run = 0;
         busy_hits = 0;
         ramp_hits = 0;
         foreach (stamps[i]) stamps[i] = 0;
      endfunction

      function void set_threshold(bit [15:0] value);
         threshold = value;
      endfunction

      // Update the run counter and the stamp ring, then score from the updated state.
      function void note_attempt(bit [15:0] score, bit ok, bit [31:0] now);
         bit [31:0] f, p, q, lo, total, age;
         int unsigned recent;
         score_set_type s;
         recent = 0;
         if (ok) fail_run = 0;
         else if (fail_run != FAIL_CAP) fail_run++;
         if (fail_run > peak_run) peak_run = fail_run;
         stamps[slot] = now;
         slot = (slot + 1) % RING_DEPTH;
         if (filled < RING_DEPTH) filled++;

         if (fail_run == 0) f = 0;
         else if (fail_run >= RUN_LIMIT) f = Q_ONE;
         else f = (32'(fail_run) * 32'(Q_ONE)) / RUN_LIMIT;

         lo = (32'(threshold) * 3) / 10;
         if (32'(score) < lo || 32'(score) >= 32'(threshold)) p = 0;
         else p = ((32'(score) - lo) * 32'(Q_ONE)) / (32'(threshold) - lo);

         for (int i = 0; i < filled; i++) begin
            age = now - stamps[i];
            if (age < RECENT_SPAN_MS) recent++;
         end
         if (recent <= QUIET_COUNT) q = 0;
         else q = ((recent - QUIET_COUNT) * 32'(Q_ONE)) / QUIET_COUNT;
         if (q > Q_ONE) q = Q_ONE;

         total = (40 * f + 35 * p + 25 * q) / 100;
         if (total > Q_ONE) total = Q_ONE;
         if (q != 0) busy_hits++;
         if (p != 0) ramp_hits++;

         s.anomaly_score  = total[15:0];
         s.failure_part   = f[15:0];
         s.proximity_part = p[15:0];
         s.frequency_part = q[15:0];
         pending_scores.push_back(s);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            mismatches++;
         end
      endfunction

      function void check_scores(score_set_type seen);
         score_set_type want;
         if (pending_scores.size() == 0) begin
            $error("response with no request waiting");
            mismatches++;
            return;
         end
         want = pending_scores.pop_front();
         checked++;
         compare_field("anomaly_score", want.anomaly_score, seen.anomaly_score);
         compare_field("failure_part", want.failure_part, seen.failure_part);
         compare_field("proximity_part", want.proximity_part, seen.proximity_part);
         compare_field("frequency_part", want.frequency_part, seen.frequency_part);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   sias_req_if req_bus ();
   sias_rsp_if rsp_bus ();

   score_ledger_type ledger = new();
   int unsigned idle_cycles;
   int unsigned phases_run;

   sign_in_anomaly_scorer dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Match scores cluster around both ends of the proximity ramp.
   function automatic bit [15:0] pick_score(bit [15:0] thr);
      bit [31:0] lo;
      lo = (32'(thr) * 3) / 10;
      case ($urandom_range(0, 9))
         0: return lo[15:0];
         1: return (lo > 0) ? lo[15:0] - 16'd1 : 16'd0;
         2: return (thr > 0) ? thr - 16'd1 : 16'd0;
         3: return thr;
         4: return 16'hFFFF;
         5: return 16'h0000;
         6: return 16'($urandom);
         default: begin
            if (32'(thr) > lo) return 16'($urandom_range(lo, 32'(thr) - 1));
            return 16'($urandom);
         end
      endcase
   endfunction

   task automatic attempt(bit [15:0] score, bit ok, bit [31:0] now, int unsigned gap);
      req_bus.valid       <= 1'b1;
      req_bus.match_score <= score;
      req_bus.succeeded   <= ok;
      req_bus.time_ms     <= now;
      do @(posedge clock); while (!req_bus.ready);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_threshold(bit [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold off new requests until every score has come back, then let the back end settle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (ledger.pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      bit [31:0] base;
      base = 32'hFFFF_FFF0;
      // Timestamps straddle the 32-bit wrap; the failure run climbs past the limit.
      attempt(16'd0,     1'b0, base,           0);
      attempt(16'd65535, 1'b0, base + 32'd4,   0);
      attempt(16'd9830,  1'b0, base + 32'd8,   2);
      attempt(16'd9829,  1'b0, base + 32'd12,  0);
      attempt(16'd9831,  1'b0, base + 32'd16,  0);
      attempt(16'd32767, 1'b0, base + 32'd20,  5);
      attempt(16'd32768, 1'b0, base + 32'd24,  0);
      attempt(16'd20000, 1'b1, base + 32'd28,  0);
      // The first stamp is exactly one span old here, the second just under it.
      attempt(16'd20000, 1'b0, base + 32'd60000, 0);
      attempt(16'd21000, 1'b0, base + 32'd60001, 0);
      attempt(16'd25000, 1'b1, base + 32'd60002, 1);
      attempt(16'd30000, 1'b0, base + 32'd60010, 0);
      attempt(16'd12345, 1'b0, base + 32'd60020, 0);
      attempt(16'd32000, 1'b0, base + 32'd60030, 0);
      attempt(16'd10000, 1'b0, base + 32'd60040, 0);
      attempt(16'd31000, 1'b0, base + 32'd60050, 0);
      settle();
      // A zero threshold leaves no ramp at all.
      write_threshold(16'd0);
      attempt(16'd0,     1'b1, 32'h8000_0000, 0);
      attempt(16'd65535, 1'b0, 32'h8000_0001, 0);
      attempt(16'd1,     1'b0, 32'h8000_0002, 0);
      settle();
      write_threshold(16'hFFFF);
      attempt(16'd19660, 1'b0, 32'h0000_1000, 0);
      attempt(16'd65534, 1'b1, 32'h0000_2000, 0);
      attempt(16'd65535, 1'b0, 32'h0000_3000, 0);
      settle();
      write_threshold(16'd3);
      attempt(16'd0, 1'b0, 32'h0001_0000, 0);
      attempt(16'd2, 1'b0, 32'h0001_0001, 0);
      settle();
   endtask

   // One phase: a threshold write, then attempts that are mostly well-formed sequences
   // with a steadily advancing clock, and some noise.
   task automatic run_phase(bit [15:0] thr, int unsigned count, bit storm, bit eager);
      bit [31:0]   clock_ms;
      bit [31:0]   now;
      bit [15:0]   score;
      bit          ok;
      int unsigned gap;
      write_threshold(thr);
      clock_ms = $urandom;
      for (int unsigned i = 0; i < count; i++) begin
         if (storm) ok = (i + 3 >= count);
         else ok = ($urandom_range(0, 99) < 35);
         if ($urandom_range(0, 99) < 80) begin
            case ($urandom_range(0, 19))
               0: clock_ms += RECENT_SPAN_MS;
               1: clock_ms += RECENT_SPAN_MS - 32'd1;
               2: clock_ms += $urandom_range(20000, 90000);
               default: clock_ms += $urandom_range(0, 9000);
            endcase
            now   = clock_ms;
            score = pick_score(thr);
         end else begin
            now   = $urandom;
            score = 16'($urandom);
            if (!storm) ok = 1'($urandom_range(0, 1));
         end
         gap = eager ? 0 : pick_gap();
         attempt(score, ok, now, gap);
      end
      settle();
      phases_run++;
   endtask

   initial begin
      phases_run = 0;
      req_bus.valid       <= 1'b0;
      req_bus.match_score <= '0;
      req_bus.succeeded   <= 1'b0;
      req_bus.time_ms     <= '0;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;
      reset               <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_phase(16'hFFFF, 70, 1'b0, 1'b0);
      run_phase(16'h0000, 70, 1'b0, 1'b1);
      run_phase(16'd1, 60, 1'b0, 1'b0);
      run_phase(16'($urandom), 300, 1'b1, 1'b0);
      run_phase(16'd10, 60, 1'b0, 1'b1);
      run_phase(16'($urandom_range(0, 65535)), 70, 1'b0, 1'b0);
      run_phase(16'd40000, 70, 1'b0, 1'b1);

      $display("Scored %0d attempts over %0d threshold phases plus directed cases.",
               ledger.checked, phases_run);
      $display("Longest failure run %0d; %0d busy-window and %0d near-threshold results.",
               ledger.peak_run, ledger.busy_hits, ledger.ramp_hits);
      if (ledger.mismatches == 0 && ledger.pending_scores.size() == 0) begin
         $display("sign_in_anomaly_scorer: match");
      end else begin
         $display("sign_in_anomaly_scorer: mismatch");
      end
      $finish;
   end

   // Response side: random stalls, with occasional long stretches of steady readiness.
   initial begin
      int unsigned stall;
      int unsigned run;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         run   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) ledger.set_threshold(csr_wdata);
         if (req_bus.valid && req_bus.ready)
            ledger.note_attempt(req_bus.match_score, req_bus.succeeded, req_bus.time_ms);
         if (rsp_bus.valid && rsp_bus.ready)
            ledger.check_scores('{rsp_bus.anomaly_score, rsp_bus.failure_part,
                                  rsp_bus.proximity_part, rsp_bus.frequency_part});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("sign_in_anomaly_scorer: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
